/* rtl/usbpss_pkg.sv */
// Package for the USB root port status shadow: command and kind codes, PORTSC
// bit positions, request and result structs, queue sizing.
// No dependencies.
package usbpss_pkg;

   typedef enum logic [2:0] {
      CMD_UPDATE = 3'd0,
      CMD_REPORT = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_ARM    = 3'd3,
      CMD_CLAIM  = 3'd4,
      CMD_AGE    = 3'd5
   } cmd_code_type;

   typedef enum logic [2:0] {
      KIND_NOP    = 3'd0,
      KIND_UPDATE = 3'd1,
      KIND_REPORT = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_ARM    = 3'd4,
      KIND_CLAIM  = 3'd5,
      KIND_AGE    = 3'd6
   } kind_type;

   // PORTSC bit positions
   localparam int PSC_CCS = 0;
   localparam int PSC_PED = 1;
   localparam int PSC_OCA = 3;
   localparam int PSC_PR  = 4;
   localparam int PSC_PLS_LO = 5;
   localparam int PSC_PLS_HI = 8;
   localparam int PSC_PP  = 9;
   localparam int PSC_CSC = 17;
   localparam int PSC_PEC = 18;
   localparam int PSC_OCC = 20;
   localparam int PSC_PRC = 21;
   localparam int PSC_PLC = 22;
   localparam int PSC_CHG_LO = 17;
   localparam int PSC_CHG_HI = 23;

   localparam logic [3:0]  PLS_U3      = 4'd3;
   localparam logic [3:0]  PLS_RESUME  = 4'd15;
   localparam logic [31:0] PSC_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] AGE_LIMIT_RESET = 32'd500;

   // hub change bits
   localparam int HUB_C_CONNECT = 0;
   localparam int HUB_C_ENABLE  = 1;
   localparam int HUB_C_SUSPEND = 2;
   localparam int HUB_C_OVERCUR = 3;
   localparam int HUB_C_RESET   = 4;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      kind_type    kind;
      logic [31:0] portsc;
      logic [2:0]  speed;
      logic [4:0]  latched_base;
      logic        resume_cand;
      logic [4:0]  clr_mask;
      logic [1:0]  op;
      logic [31:0] gen;
      logic        gen_nz;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic        flag;
      logic [4:0]  latched;
      logic [23:0] ack;
      logic [31:0] gen_out;
      logic [10:0] status;
      logic [4:0]  change;
   } rsp_type;

   typedef struct packed {
      logic armed;
      logic gen_nz;
   } mon_type;

   function automatic logic in_suspend(input logic [3:0] pls);
      return (pls == PLS_U3) || (pls == PLS_RESUME);
   endfunction

   function automatic logic [Q_PTR_W-1:0] q_next(input logic [Q_PTR_W-1:0] p);
      return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

/* rtl/usbpss_front.sv */
// Front end: accepts requests, decodes and pre-classifies them, and holds
// them in a short queue for the back end. Depends on usbpss_pkg.
module usbpss_front import usbpss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_portsc_value,
   input  logic [2:0]  req_speed_class,
   input  logic [7:0]  req_change_bits,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_generation,
   input  logic [31:0] req_now_ms,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd_data
);

   cmd_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;
   cmd_type             dec;
   logic                enq, deq;

   always_comb begin
      dec = '0;
      dec.portsc       = req_portsc_value;
      dec.speed        = req_portsc_value[PSC_CCS] ? req_speed_class : 3'd0;
      dec.latched_base[HUB_C_CONNECT] = req_portsc_value[PSC_CSC];
      dec.latched_base[HUB_C_ENABLE]  = req_portsc_value[PSC_PEC];
      dec.latched_base[HUB_C_OVERCUR] = req_portsc_value[PSC_OCC];
      dec.latched_base[HUB_C_RESET]   = req_portsc_value[PSC_PRC];
      dec.resume_cand  = req_portsc_value[PSC_PLC] && req_portsc_value[PSC_PED]
                         && req_portsc_value[PSC_CCS]
                         && !in_suspend(req_portsc_value[PSC_PLS_HI:PSC_PLS_LO]);
      dec.clr_mask     = (req_change_bits[7:5] == 3'd0) ? req_change_bits[4:0] : 5'd0;
      dec.op           = req_operation;
      dec.gen          = req_generation;
      dec.gen_nz       = (req_generation != 32'd0);
      dec.now          = req_now_ms;
      unique case (cmd_code_type'(req_command))
         CMD_UPDATE: dec.kind = (req_portsc_value == PSC_ALL_ONES) ? KIND_NOP : KIND_UPDATE;
         CMD_REPORT: dec.kind = KIND_REPORT;
         CMD_CLEAR:  dec.kind = KIND_CLEAR;
         CMD_ARM:    dec.kind = KIND_ARM;
         CMD_CLAIM:  dec.kind = KIND_CLAIM;
         CMD_AGE:    dec.kind = KIND_AGE;
         default:    dec.kind = KIND_NOP;
      endcase
   end

   assign req_full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rptr_ff];
   assign enq       = req_push && !req_full;
   assign deq       = cmd_valid && cmd_ready;

   always_comb begin
      wptr_in = enq ? q_next(wptr_ff) : wptr_ff;
      rptr_in = deq ? q_next(rptr_ff) : rptr_ff;
      cnt_in  = cnt_ff + Q_CNT_W'(enq) - Q_CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wptr_ff] <= dec;
      end
   end

endmodule

/* rtl/usbpss_back.sv */
// Back end: executes decoded requests against the port shadow state and
// queues results for the consumer. Holds the age limit register.
// Depends on usbpss_pkg.
module usbpss_back import usbpss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_age_limit_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   output mon_type     mon
);

   logic [31:0] age_limit_ff;
   logic [31:0] last_portsc_ff, last_portsc_in;
   logic [4:0]  pending_ff, pending_in;
   logic [2:0]  speed_ff, speed_in;
   logic [1:0]  armed_ff, armed_in;
   logic [31:0] cur_gen_ff, cur_gen_in;
   logic        age_started_ff, age_started_in;
   logic [31:0] age_start_ff, age_start_in;

   rsp_type             rq_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  rwptr_ff, rrptr_ff;
   logic [Q_CNT_W-1:0]  rcnt_ff, rcnt_in;
   rsp_type             res;
   logic                run, pop;
   logic [31:0]         gen_inc, elapsed;

   assign csr_ready = 1'b1;
   assign cmd_ready = (rcnt_ff != Q_CNT_W'(Q_DEPTH));
   assign run       = cmd_valid && cmd_ready;
   assign rsp_empty = (rcnt_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_data  = rq_ff[rrptr_ff];
   assign gen_inc   = cur_gen_ff + 32'd1;
   assign elapsed   = cmd_data.now - age_start_ff;
   assign mon.armed  = (armed_ff != 2'd0);
   assign mon.gen_nz = (cur_gen_ff != 32'd0);

   always_comb begin
      res            = '0;
      last_portsc_in = last_portsc_ff;
      pending_in     = pending_ff;
      speed_in       = speed_ff;
      armed_in       = armed_ff;
      cur_gen_in     = cur_gen_ff;
      age_started_in = age_started_ff;
      age_start_in   = age_start_ff;
      unique case (cmd_data.kind)
         KIND_UPDATE: begin
            res.latched = cmd_data.latched_base;
            res.latched[HUB_C_SUSPEND] = cmd_data.resume_cand
               && in_suspend(last_portsc_ff[PSC_PLS_HI:PSC_PLS_LO]);
            res.ack = {cmd_data.portsc[PSC_CHG_HI:PSC_CHG_LO], 17'd0};
            last_portsc_in = cmd_data.portsc;
            pending_in     = pending_ff | res.latched;
            speed_in       = cmd_data.speed;
         end
         KIND_REPORT: begin
            res.status[0]  = last_portsc_ff[PSC_CCS];
            res.status[1]  = last_portsc_ff[PSC_PED];
            res.status[2]  = in_suspend(last_portsc_ff[PSC_PLS_HI:PSC_PLS_LO]);
            res.status[3]  = last_portsc_ff[PSC_OCA];
            res.status[4]  = last_portsc_ff[PSC_PR];
            res.status[8]  = last_portsc_ff[PSC_PP];
            res.status[10] = last_portsc_ff[PSC_CCS];
            res.change     = pending_ff;
         end
         KIND_CLEAR: begin
            res.flag   = |(pending_ff & cmd_data.clr_mask);
            pending_in = pending_ff & ~cmd_data.clr_mask;
         end
         KIND_ARM: begin
            if (cmd_data.op != 2'd0 && armed_ff == 2'd0) begin
               res.gen_out    = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
               cur_gen_in     = res.gen_out;
               armed_in       = cmd_data.op;
               age_started_in = 1'b0;
            end
         end
         KIND_CLAIM: begin
            if (cmd_data.gen_nz && armed_ff == cmd_data.op && cur_gen_ff == cmd_data.gen) begin
               armed_in = 2'd0;
               res.flag = 1'b1;
            end
         end
         KIND_AGE: begin
            if (armed_ff == 2'd0) begin
               age_started_in = 1'b0;
            end else if (!age_started_ff) begin
               age_started_in = 1'b1;
               age_start_in   = cmd_data.now;
            end else if (elapsed >= age_limit_ff) begin
               age_started_in = 1'b0;
               res.flag       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rcnt_in = rcnt_ff + Q_CNT_W'(run) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff   <= AGE_LIMIT_RESET;
         last_portsc_ff <= '0;
         pending_ff     <= '0;
         speed_ff       <= '0;
         armed_ff       <= '0;
         cur_gen_ff     <= '0;
         age_started_ff <= 1'b0;
         age_start_ff   <= '0;
         rwptr_ff       <= '0;
         rrptr_ff       <= '0;
         rcnt_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            age_limit_ff <= csr_age_limit_ms;
         end
         if (run) begin
            last_portsc_ff <= last_portsc_in;
            pending_ff     <= pending_in;
            speed_ff       <= speed_in;
            armed_ff       <= armed_in;
            cur_gen_ff     <= cur_gen_in;
            age_started_ff <= age_started_in;
            age_start_ff   <= age_start_in;
            rwptr_ff       <= q_next(rwptr_ff);
         end
         if (pop) begin
            rrptr_ff <= q_next(rrptr_ff);
         end
         rcnt_ff <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         rq_ff[rwptr_ff] <= res;
      end
   end

endmodule

/* rtl/usb_port_status_shadow_core.sv */
// Top level of the USB root port status shadow: front decode queue feeding
// the execute back end. Depends on usbpss_pkg, usbpss_front, usbpss_back.
//
//   channel   handshake          payload
//   req       push / full        command, portsc_value, speed_class, change_bits,
//                                operation, generation, now_ms
//   rsp       empty / pop        flag, latched_changes, ack_bits, generation_out,
//                                port_status, port_change
//   csr       valid / ready      age_limit_ms (ready always high)
//
// One request per cycle sustained while the consumer keeps popping. With no stalls an
// accepted request goes through the decode queue, then the result queue, to the rsp ports.
// Both queues are two deep: a held-off consumer fills the result queue, then the
// decode queue, and only then raises req_full.
// Synchronous reset empties both queues and clears the shadow state; age limit 500.
module usb_port_status_shadow_core import usbpss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_portsc_value,
   input  logic [2:0]  req_speed_class,
   input  logic [7:0]  req_change_bits,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_generation,
   input  logic [31:0] req_now_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_flag,
   output logic [4:0]  rsp_latched_changes,
   output logic [23:0] rsp_ack_bits,
   output logic [31:0] rsp_generation_out,
   output logic [10:0] rsp_port_status,
   output logic [4:0]  rsp_port_change,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_age_limit_ms
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;
   rsp_type rsp_data;
   mon_type mon;

   usbpss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_portsc_value (req_portsc_value),
      .req_speed_class  (req_speed_class),
      .req_change_bits  (req_change_bits),
      .req_operation    (req_operation),
      .req_generation   (req_generation),
      .req_now_ms       (req_now_ms),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_data         (cmd_data)
   );

   usbpss_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_data         (cmd_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_age_limit_ms (csr_age_limit_ms),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .mon              (mon)
   );

   assign rsp_flag            = rsp_data.flag;
   assign rsp_latched_changes = rsp_data.latched;
   assign rsp_ack_bits        = rsp_data.ack;
   assign rsp_generation_out  = rsp_data.gen_out;
   assign rsp_port_status     = rsp_data.status;
   assign rsp_port_change     = rsp_data.change;

   a_armed_gen_nz: assert property (@(posedge clock) disable iff (reset)
      mon.armed |-> mon.gen_nz)
      else $error("operation armed under generation zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> !rsp_empty)
      else $error("executed request left no result");

endmodule
